[rtl/core/lphi_pkg.sv]
// Shared constants, codes and types for the linear-probe hash index.
// Used by lphi_slot_store, lphi_seq and linear_probe_hash_index_core.
package lphi_pkg;

    // Default sizes and fixed field widths
    localparam int SLOTS_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int KEY_W          = 64;
    localparam int VALUE_W        = 32;
    localparam int OP_W           = 2;
    localparam int STATUS_W       = 3;
    localparam int IN_DATA_W      = 104;  // 98 bits of fields, padded to bytes
    localparam int OUT_DATA_W     = 40;   // 35 bits of fields, padded to bytes

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NEW     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd4;

    // Write enables toward the slot store
    typedef struct packed {
        logic key_we;
        logic val_we;
    } lphi_wr_en_t;

    // One finished result
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  found_value;
    } lphi_result_t;

endpackage

[rtl/core/lphi_slot_store.sv]
// Slot store: key memory and value memory sharing one read and one write address.
// Depends on lphi_pkg. Read data is registered.
module lphi_slot_store
    import lphi_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int STORE_W = VALUE_W
)
(
    input  logic                       clk,
    input  logic [$clog2(SLOTS)-1:0]   rd_addr,
    output logic [KEY_W-1:0]           rd_key,
    output logic [STORE_W-1:0]         rd_val,
    input  lphi_wr_en_t                wr_en,
    input  logic [$clog2(SLOTS)-1:0]   wr_addr,
    input  logic [KEY_W-1:0]           wr_key,
    input  logic [STORE_W-1:0]         wr_val
);

    logic [KEY_W-1:0]   key_mem [SLOTS];
    logic [STORE_W-1:0] val_mem [SLOTS];

    // Write key column; register the key read
    always_ff @(posedge clk)
    begin
        if (wr_en.key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        rd_key <= key_mem[rd_addr];
    end

    // Write value column; register the value read
    always_ff @(posedge clk)
    begin
        if (wr_en.val_we)
        begin
            val_mem[wr_addr] <= wr_val;
        end
        rd_val <= val_mem[rd_addr];
    end

endmodule

[rtl/core/lphi_seq.sv]
// Probe sequencer: walks slots one per cycle through a single key compare unit,
// runs the clearing sweep, and keeps the occupancy count. Depends on lphi_pkg.
module lphi_seq
    import lphi_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int STORE_W = VALUE_W
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // request side
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [OP_W-1:0]            in_op,
    input  logic [KEY_W-1:0]           in_key,
    input  logic [VALUE_W-1:0]         in_value,
    // slot store
    output logic [$clog2(SLOTS)-1:0]   rd_addr,
    input  logic [KEY_W-1:0]           rd_key,
    input  logic [STORE_W-1:0]         rd_val,
    output lphi_wr_en_t                wr_en,
    output logic [$clog2(SLOTS)-1:0]   wr_addr,
    output logic [KEY_W-1:0]           wr_key,
    output logic [STORE_W-1:0]         wr_val,
    // result side
    output logic                       res_valid,
    input  logic                       res_ready,
    output lphi_result_t               res
);

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS);
    localparam logic [CNT_W-1:0]  HALF     = CNT_W'(SLOTS / 2);
    localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(SLOTS - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_PROBE, S_DONE} state_t;

    state_t              state_reg,  state_next;
    logic [ADDR_W-1:0]   addr_reg,   addr_next;
    logic [OP_W-1:0]     op_reg,     op_next;
    logic [KEY_W-1:0]    key_reg,    key_next;
    logic [STORE_W-1:0]  val_reg,    val_next;
    logic [CNT_W-1:0]    used_reg,   used_next;
    logic                clr_op_reg, clr_op_next;
    lphi_result_t        res_reg,    res_next;

    logic key_match;
    logic slot_empty;

    // Shared compare unit on the slot just read
    assign key_match  = (rd_key == key_reg);
    assign slot_empty = (rd_key == '0);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // Next-state and memory control
    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        used_next   = used_reg;
        clr_op_next = clr_op_reg;
        res_next    = res_reg;
        rd_addr     = addr_reg + ADDR_W'(1);
        wr_en       = '0;
        wr_addr     = addr_reg;
        wr_key      = key_reg;
        wr_val      = val_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Empty one slot per cycle
                wr_en.key_we = 1'b1;
                wr_key       = '0;
                addr_next    = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_MAX)
                begin
                    used_next = '0;
                    if (clr_op_reg)
                    begin
                        res_next   = '{status: ST_HIT, found_value: '0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_IDLE:
            begin
                // Start reading the home slot as the request is taken
                rd_addr = in_key[ADDR_W-1:0];
                if (in_valid)
                begin
                    op_next     = in_op;
                    key_next    = in_key;
                    val_next    = in_value[STORE_W-1:0];
                    addr_next   = in_key[ADDR_W-1:0];
                    clr_op_next = 1'b0;
                    res_next    = '{status: ST_REFUSED, found_value: '0};
                    unique case (in_op)
                        OP_LOOKUP:
                        begin
                            if (in_key == '0)
                            begin
                                res_next.status = ST_MISS;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_PROBE;
                            end
                        end
                        OP_INSERT:
                        begin
                            state_next = (in_key == '0) ? S_DONE : S_PROBE;
                        end
                        OP_CLEAR:
                        begin
                            addr_next   = '0;
                            clr_op_next = 1'b1;
                            state_next  = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_PROBE:
            begin
                // Half load guarantees an empty slot ends every miss
                if (key_match)
                begin
                    if (op_reg == OP_LOOKUP)
                    begin
                        res_next = '{status: ST_HIT, found_value: VALUE_W'(rd_val)};
                    end
                    else
                    begin
                        wr_en.val_we    = 1'b1;
                        res_next.status = ST_UPDATED;
                    end
                    state_next = S_DONE;
                end
                else if (slot_empty)
                begin
                    if (op_reg == OP_LOOKUP)
                    begin
                        res_next.status = ST_MISS;
                    end
                    else if (used_reg < HALF)
                    begin
                        wr_en.key_we    = 1'b1;
                        wr_en.val_we    = 1'b1;
                        used_next       = used_reg + CNT_W'(1);
                        res_next.status = ST_NEW;
                    end
                    else
                    begin
                        res_next.status = ST_REFUSED;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    // Advance to the next slot with wrap
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs; reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            addr_reg   <= '0;
            op_reg     <= OP_LOOKUP;
            key_reg    <= '0;
            val_reg    <= '0;
            used_reg   <= '0;
            clr_op_reg <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            op_reg     <= op_next;
            key_reg    <= key_next;
            val_reg    <= val_next;
            used_reg   <= used_next;
            clr_op_reg <= clr_op_next;
            res_reg    <= res_next;
        end
    end

    // Occupancy never passes half the table
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= HALF)
        else $error("occupancy above half load");

    // Outside the sweep, only nonzero keys are stored
    a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en.key_we && state_reg != S_CLEAR) |-> (wr_key != '0))
        else $error("zero key stored by insert");

    // A new key bumps the occupancy by one
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en.key_we && state_reg == S_PROBE)
        |=> (used_reg == $past(used_reg) + CNT_W'(1)))
        else $error("occupancy not advanced on new key");

    // A taken request always occupies the sequencer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("sequencer idle right after request");

endmodule

[rtl/core/linear_probe_hash_index_core.sv]
// Linear-probe hash index: lookup, insert/update and clear over a fixed slot table.
// Each request is taken, then probes one slot per cycle until a key match or an empty slot
// (none for a zero key or the spare op); the result passes the sequencer's result register
// and the output register; requests are taken one at a time. Clear and reset sweep the key
// memory one slot per cycle; reset (rst_n low, asynchronous) holds s_tready low meanwhile.
// Depends on lphi_pkg, lphi_slot_store and lphi_seq.
module linear_probe_hash_index_core
    import lphi_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // op[1:0], key[65:2], value[97:66], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // status[2:0], found_value[34:3], zero pad
);

    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int STORE_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

    logic [ADDR_W-1:0]  rd_addr;
    logic [KEY_W-1:0]   rd_key;
    logic [STORE_W-1:0] rd_val;
    lphi_wr_en_t        wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [KEY_W-1:0]   wr_key;
    logic [STORE_W-1:0] wr_val;
    logic               res_valid;
    logic               res_ready;
    lphi_result_t       res;

    logic               m_tvalid_reg, m_tvalid_next;
    lphi_result_t       m_res_reg,    m_res_next;

    lphi_slot_store #(
        .SLOTS   (SLOTS),
        .STORE_W (STORE_W)
    ) u_store (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_val  (rd_val),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_val  (wr_val)
    );

    lphi_seq #(
        .SLOTS   (SLOTS),
        .STORE_W (STORE_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[OP_W-1:0]),
        .in_key    (s_tdata[OP_W +: KEY_W]),
        .in_value  (s_tdata[OP_W + KEY_W +: VALUE_W]),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_val    (rd_val),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_key    (wr_key),
        .wr_val    (wr_val),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: take a result whenever the slot is free or draining
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            m_res_reg    <= '0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            m_res_reg    <= m_res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - STATUS_W - VALUE_W){1'b0}},
                       m_res_reg.found_value, m_res_reg.status};

endmodule
